/* hdl/otimer_pkg.sv */
// Shared constants, codes and structs of the one-shot timer table.
package otimer_pkg;

    localparam int SLOTS    = 10;
    localparam int TAG_BITS = 16;
    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int DL_BITS  = 32;
    localparam int MEM_W    = TAG_BITS + DL_BITS;

    typedef enum logic [1:0] {
        CMD_CREATE = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_TICK   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_ZERO_TIMEOUT = 2'd1,
        ST_FULL         = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [15:0] callback_tag;
        logic [31:0] timeout;
        logic [3:0]  slot_number;
    } req_t;

    typedef struct packed {
        logic [31:0] tick_now;
        logic [15:0] fired_tag;
        logic [3:0]  fired_slot;
        logic        fired;
        logic [3:0]  allocated_slot;
        status_t     status;
    } res_t;

    typedef struct packed {
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        logic [MEM_W-1:0]  wr_data;
        logic [SLOT_W-1:0] rd_addr;
    } mem_req_t;

endpackage

/* hdl/otimer_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module otimer_ram #(
    parameter int DEPTH = 10,
    parameter int WIDTH = 48,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/otimer_core.sv */
// Request sequencer: active flags, tick counter and the expiry scan over the timer RAM.
module otimer_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  otimer_pkg::req_t              req,
    output logic                          res_valid,
    input  logic                          res_ready,
    output otimer_pkg::res_t              res,
    output otimer_pkg::mem_req_t          mem_req,
    input  logic [otimer_pkg::MEM_W-1:0]  mem_rdata
);

    otimer_pkg::state_t                state_reg, state_next;
    logic [otimer_pkg::SLOTS-1:0]      active_reg, active_next;
    logic [31:0]                       tick_reg, tick_next;
    logic [otimer_pkg::CNT_W-1:0]      scan_idx_reg, scan_idx_next;
    logic                              pend_valid_reg, pend_valid_next;
    logic [otimer_pkg::SLOT_W-1:0]     pend_idx_reg, pend_idx_next;
    otimer_pkg::res_t                  res_reg, res_next;

    logic                              free_found;
    logic [otimer_pkg::SLOT_W-1:0]     free_idx;
    logic [31:0]                       rd_deadline;
    logic [otimer_pkg::TAG_BITS-1:0]   rd_tag;
    logic                              in_fire;

    assign rd_deadline = mem_rdata[otimer_pkg::DL_BITS-1:0];
    assign rd_tag      = mem_rdata[otimer_pkg::MEM_W-1:otimer_pkg::DL_BITS];
    assign in_fire     = in_valid && in_ready;

    // Lowest free slot; scanning downward leaves the lowest one last.
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = otimer_pkg::SLOTS - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = otimer_pkg::SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        active_next     = active_reg;
        tick_next       = tick_reg;
        scan_idx_next   = scan_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        res_next        = res_reg;
        in_ready        = 1'b0;
        res_valid       = 1'b0;
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = free_idx;
        mem_req.wr_data = {otimer_pkg::TAG_BITS'(req.callback_tag), tick_reg + req.timeout};
        mem_req.rd_addr = scan_idx_reg[otimer_pkg::SLOT_W-1:0];

        unique case (state_reg)
            otimer_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    res_next          = '0;
                    res_next.tick_now = tick_reg;
                    res_next.status   = otimer_pkg::ST_OK;
                    state_next        = otimer_pkg::S_DONE;
                    case (req.cmd)
                        otimer_pkg::CMD_CREATE:
                        begin
                            if (req.timeout == 32'd0)
                            begin
                                res_next.status = otimer_pkg::ST_ZERO_TIMEOUT;
                            end
                            else if (!free_found)
                            begin
                                res_next.status = otimer_pkg::ST_FULL;
                            end
                            else
                            begin
                                active_next[free_idx]   = 1'b1;
                                mem_req.wr_en           = 1'b1;
                                res_next.allocated_slot = 4'(free_idx);
                            end
                        end
                        otimer_pkg::CMD_DELETE:
                        begin
                            if (32'(req.slot_number) < otimer_pkg::SLOTS)
                            begin
                                active_next[otimer_pkg::SLOT_W'(req.slot_number)] = 1'b0;
                            end
                        end
                        otimer_pkg::CMD_TICK:
                        begin
                            tick_next         = tick_reg + 32'd1;
                            res_next.tick_now = tick_reg + 32'd1;
                            scan_idx_next     = '0;
                            pend_valid_next   = 1'b0;
                            state_next        = otimer_pkg::S_SCAN;
                        end
                        default:
                        begin
                            // The unused command code leaves the active flags and the tick counter alone.
                        end
                    endcase
                end
            end
            otimer_pkg::S_SCAN:
            begin
                // One RAM read is issued per cycle while the previous read is checked.
                if (pend_valid_reg && active_reg[pend_idx_reg] && (tick_reg >= rd_deadline))
                begin
                    active_next[pend_idx_reg] = 1'b0;
                    res_next.fired            = 1'b1;
                    res_next.fired_slot       = 4'(pend_idx_reg);
                    res_next.fired_tag        = 16'(rd_tag);
                    pend_valid_next           = 1'b0;
                    state_next                = otimer_pkg::S_DONE;
                end
                else if (32'(scan_idx_reg) < otimer_pkg::SLOTS)
                begin
                    pend_valid_next = 1'b1;
                    pend_idx_next   = scan_idx_reg[otimer_pkg::SLOT_W-1:0];
                    scan_idx_next   = scan_idx_reg + otimer_pkg::CNT_W'(1);
                end
                else
                begin
                    pend_valid_next = 1'b0;
                    if (!pend_valid_reg)
                    begin
                        state_next = otimer_pkg::S_DONE;
                    end
                end
            end
            otimer_pkg::S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = otimer_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = otimer_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= otimer_pkg::S_IDLE;
            active_reg     <= '0;
            tick_reg       <= '0;
            scan_idx_reg   <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            active_reg     <= active_next;
            tick_reg       <= tick_next;
            scan_idx_reg   <= scan_idx_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        res_reg      <= res_next;
    end

    assign res = res_reg;

    a_tick_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_fire && (req.cmd == otimer_pkg::CMD_TICK)) |=> tick_reg == $past(tick_reg))
        else $error("tick counter moved without a tick request");

    a_create_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (req.cmd == otimer_pkg::CMD_CREATE) && (req.timeout != 32'd0) && free_found)
        |=> active_reg[$past(free_idx)])
        else $error("successful create left its slot free");

    a_fired_slot_freed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == otimer_pkg::S_DONE && res_reg.fired)
        |-> !active_reg[otimer_pkg::SLOT_W'(res_reg.fired_slot)])
        else $error("expired slot is still active");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(scan_idx_reg) <= otimer_pkg::SLOTS)
        else $error("scan index ran past the table");

endmodule

/* hdl/one_shot_timer_table.sv */
// Top level of the one-shot timer table: stream ports, output register and timer RAM.
//
// Requests arrive on the s_ group; s_tuser carries the command (create, delete,
// tick) and s_tdata the tag, timeout and slot number. Each request produces one
// result on the m_ group: status, allocated slot, expiry report and tick count.
// One request is processed at a time. For create, delete and the unused command
// the core registers the result and offers it to the output register; the next
// request is taken only once that result has entered it. For a tick the core first
// runs the expiry scan: it reads one timer RAM entry per cycle and stops at the
// first expired active slot, or after the last slot. Active flags and the tick
// counter are in flip-flops; tags and deadlines live in the RAM and are read for
// every slot in turn, the active flag deciding whether a slot can expire.
// Reset clears every active flag and the tick counter at once; no clearing pass.
// A finished result sits in the output register; while the receiver stalls the
// block still accepts and processes the next request, and holds its result
// until the output register frees up.
module one_shot_timer_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // callback_tag, timeout, slot_number, zero fill
    input  logic [1:0]  s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // status, allocated_slot, fired, fired_slot,
                                   // fired_tag, tick_now, zero fill
);

    otimer_pkg::req_t      req;
    otimer_pkg::res_t      res;
    otimer_pkg::mem_req_t  mem_req;
    logic [otimer_pkg::MEM_W-1:0] mem_rdata;
    logic                  res_valid;
    logic                  res_ready;
    logic                  out_valid_reg, out_valid_next;
    logic [63:0]           out_data_reg;

    assign req.cmd          = otimer_pkg::cmd_t'(s_tuser);
    assign req.callback_tag = s_tdata[15:0];
    assign req.timeout      = s_tdata[47:16];
    assign req.slot_number  = s_tdata[51:48];

    otimer_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    otimer_ram #(
        .DEPTH (otimer_pkg::SLOTS),
        .WIDTH (otimer_pkg::MEM_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.wr_en),
        .waddr (mem_req.wr_addr),
        .wdata (mem_req.wr_data),
        .raddr (mem_req.rd_addr),
        .rdata (mem_rdata)
    );

    // The register can take a new result when empty or when its content leaves now.
    assign res_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= {5'd0, res};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
